### rtl/assert_macros.svh
// Assertion macros for the checker file (spk_checker.sv) of the Speck-64 cipher block.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SPK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spk check failed");

// antecedent implies consequent in the next cycle
`define SPK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spk check failed");

`endif

### rtl/spk_pkg.sv
// Package for the Speck-64 cipher block: payload structs, register codes,
// state type and rotate helpers. No dependencies.
package spk_pkg;

  localparam int WORD_W      = 32;
  localparam int MAX_ROUNDS  = 27;
  localparam int KEY_AW      = $clog2(MAX_ROUNDS);
  localparam int SPECK_A     = 8;
  localparam int SPECK_B     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KEY_AW-1:0] ROUNDS_SHORT = KEY_AW'(26);
  localparam logic [KEY_AW-1:0] ROUNDS_LONG  = KEY_AW'(27);

  localparam logic [CFG_IDX_W-1:0] REG_KEY0     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY1     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY2     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KEY3     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = CFG_IDX_W'(4);

  typedef struct packed {
    logic [WORD_W-1:0] low_word;
    logic [WORD_W-1:0] high_word;
    logic              mode;
  } spk_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_low;
    logic [WORD_W-1:0] result_high;
  } spk_out_t;

  typedef struct packed {
    logic [WORD_W-1:0] key_word0;
    logic [WORD_W-1:0] key_word1;
    logic [WORD_W-1:0] key_word2;
    logic [WORD_W-1:0] key_word3;
    logic              key_size;
    logic              rekey;
  } spk_key_cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXPAND,
    BK_ROUND,
    BK_DONE
  } spk_back_state_t;

  function automatic logic [WORD_W-1:0] rot_right(input logic [WORD_W-1:0] v, input int amt);
    rot_right = (v >> amt) | (v << (WORD_W - amt));
  endfunction

  function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v, input int amt);
    rot_left = (v << amt) | (v >> (WORD_W - amt));
  endfunction

endpackage

### rtl/spk_front.sv
// Front end of the Speck-64 cipher: key configuration registers and the
// two-entry item queue that feeds the round engine. Depends on spk_pkg.
module spk_front import spk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spk_in_t              in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output spk_key_cfg_t         key_cfg,
  output logic                 q_valid,
  output spk_in_t              q_item,
  input  logic                 q_pop
);

  logic [WORD_W-1:0]   key0_r, key1_r, key2_r, key3_r;
  logic [WORD_W-1:0]   key0_nxt, key1_nxt, key2_nxt, key3_nxt;
  logic                key_size_r, key_size_nxt;
  logic                rekey;
  logic                cfg_wr;
  spk_in_t             q_mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                push;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_comb begin
    key0_nxt     = key0_r;
    key1_nxt     = key1_r;
    key2_nxt     = key2_r;
    key3_nxt     = key3_r;
    key_size_nxt = key_size_r;
    rekey        = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_index)
        REG_KEY0: begin
          key0_nxt = cfg_data;
          rekey    = 1'b1;
        end
        REG_KEY1: begin
          key1_nxt = cfg_data;
          rekey    = 1'b1;
        end
        REG_KEY2: begin
          key2_nxt = cfg_data;
          rekey    = 1'b1;
        end
        REG_KEY3: begin
          key3_nxt = cfg_data;
          rekey    = 1'b1;
        end
        REG_KEY_SIZE: begin
          key_size_nxt = cfg_data[0];
          rekey        = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r     <= '0;
      key1_r     <= '0;
      key2_r     <= '0;
      key3_r     <= '0;
      key_size_r <= 1'b0;
    end else begin
      key0_r     <= key0_nxt;
      key1_r     <= key1_nxt;
      key2_r     <= key2_nxt;
      key3_r     <= key3_nxt;
      key_size_r <= key_size_nxt;
    end
  end

  assign key_cfg.key_word0 = key0_r;
  assign key_cfg.key_word1 = key1_r;
  assign key_cfg.key_word2 = key2_r;
  assign key_cfg.key_word3 = key3_r;
  assign key_cfg.key_size  = key_size_r;
  assign key_cfg.rekey     = rekey;

  assign in_ready = (count_r != QUEUE_CW'(QUEUE_DEPTH));
  assign push     = in_valid & in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_item;
    end
  end

endmodule

### rtl/spk_back.sv
// Back end of the Speck-64 cipher: key schedule, round-key memory, one-round-
// per-cycle round engine and the output register. Depends on spk_pkg.
module spk_back import spk_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  spk_key_cfg_t key_cfg,
  input  logic         q_valid,
  input  spk_in_t      q_item,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output spk_out_t     out_item
);

  spk_back_state_t   state_r, state_nxt;
  logic              keys_valid_r, keys_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KEY_AW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [WORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic              mode_r, mode_nxt;
  logic [WORD_W-1:0] k_r, k_nxt, l0_r, l0_nxt, l1_r, l1_nxt, l2_r, l2_nxt;
  spk_out_t          out_item_r, out_item_nxt;

  logic [WORD_W-1:0] rkey_mem [MAX_ROUNDS];
  logic [WORD_W-1:0] rkey_r;
  logic              mem_we;
  logic [KEY_AW-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [KEY_AW-1:0] n_rounds;
  logic [WORD_W-1:0] new_l, new_k;
  logic [WORD_W-1:0] x_enc, y_enc, y_dec, x_dec;
  logic              last_round;

  assign n_rounds = key_cfg.key_size ? ROUNDS_LONG : ROUNDS_SHORT;

  assign new_l = (k_r + rot_right(l0_r, SPECK_A)) ^ WORD_W'(cnt_r);
  assign new_k = rot_left(k_r, SPECK_B) ^ new_l;

  assign x_enc = (rot_right(x_r, SPECK_A) + y_r) ^ rkey_r;
  assign y_enc = rot_left(y_r, SPECK_B) ^ x_enc;
  assign y_dec = rot_right(y_r ^ x_r, SPECK_B);
  assign x_dec = rot_left((x_r ^ rkey_r) - y_dec, SPECK_A);

  assign last_round = (cnt_r == n_rounds - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    keys_valid_nxt = keys_valid_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_item_nxt   = out_item_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    mode_nxt       = mode_r;
    k_nxt          = k_r;
    l0_nxt         = l0_r;
    l1_nxt         = l1_r;
    l2_nxt         = l2_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = new_k;
    mem_raddr      = idx_r;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (!keys_valid_r) begin
            k_nxt     = key_cfg.key_word0;
            l0_nxt    = key_cfg.key_word1;
            l1_nxt    = key_cfg.key_word2;
            l2_nxt    = key_cfg.key_word3;
            cnt_nxt   = '0;
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = key_cfg.key_word0;
            state_nxt = BK_EXPAND;
          end else begin
            q_pop     = 1'b1;
            x_nxt     = q_item.high_word;
            y_nxt     = q_item.low_word;
            mode_nxt  = q_item.mode;
            cnt_nxt   = '0;
            idx_nxt   = q_item.mode ? n_rounds - 1'b1 : '0;
            mem_raddr = idx_nxt;
            state_nxt = BK_ROUND;
          end
        end
      end
      BK_EXPAND: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r + 1'b1;
        k_nxt     = new_k;
        l0_nxt    = l1_r;
        if (key_cfg.key_size) begin
          l1_nxt = l2_r;
          l2_nxt = new_l;
        end else begin
          l1_nxt = new_l;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == n_rounds - KEY_AW'(2)) begin
          keys_valid_nxt = 1'b1;
          state_nxt      = BK_IDLE;
        end
      end
      BK_ROUND: begin
        x_nxt   = mode_r ? x_dec : x_enc;
        y_nxt   = mode_r ? y_dec : y_enc;
        cnt_nxt = cnt_r + 1'b1;
        if (last_round) begin
          state_nxt = BK_DONE;
        end else begin
          idx_nxt   = mode_r ? idx_r - 1'b1 : idx_r + 1'b1;
          mem_raddr = idx_nxt;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.result_low  = y_r;
          out_item_nxt.result_high = x_r;
          state_nxt                = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    if (key_cfg.rekey) begin
      keys_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      keys_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      keys_valid_r <= keys_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    mode_r     <= mode_nxt;
    k_r        <= k_nxt;
    l0_r       <= l0_nxt;
    l1_r       <= l1_nxt;
    l2_r       <= l2_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rkey_mem[mem_waddr] <= mem_wdata;
    end
    rkey_r <= rkey_mem[mem_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/speck64_block_cipher.sv
// Top level of the Speck-64 block cipher (96-bit or 128-bit key, ECB).
// Depends on spk_pkg, spk_front and spk_back.
//
// Usage:
//   cfg_*  : write key words (index 0..3) and key size (index 4, bit 0 set
//            selects the 128-bit key with 27 rounds, clear 26 rounds).
//            Always ready. Write only while no item is in flight.
//   in_*   : one item is a 64-bit block plus mode (0 encrypt, 1 decrypt).
//   out_*  : one result item per input item, in order.
// Operation:
//   An item goes through an issue step, then its rounds (n = 26 or 27),
//   one round per cycle on a single round unit fed by the round-key
//   memory, then a step that loads the output register. The engine
//   starts the next item only after it has loaded that register.
//   The first item after reset or a key write first waits for the key
//   schedule: a load step, then the expansion steps.
//   A two-entry queue takes items while the engine works; a stalled
//   receiver holds the result and, once the queue fills, in_ready drops.
//   Reset clears the key registers, the queue and the round-key status.
module speck64_block_cipher import spk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spk_in_t              in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spk_out_t             out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  spk_key_cfg_t key_cfg;
  logic         q_valid;
  spk_in_t      q_item;
  logic         q_pop;

  spk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_cfg   (key_cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  spk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_cfg   (key_cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### rtl/spk_checker.sv
// Port-level checker for the Speck-64 cipher top level, bound to it below.
// Depends on spk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spk_checker import spk_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input spk_out_t out_item
);

  logic [2:0] pending_r, pending_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  always_comb begin
    pending_nxt = pending_r + {2'b00, in_acc} - {2'b00, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `SPK_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
  `SPK_ASSERT_IMP(a_no_extra_result, out_valid, pending_r != 3'd0)
  `SPK_ASSERT_IMP(a_capacity, 1'b1, pending_r <= 3'd4)
  `SPK_ASSERT_NXT(a_no_instant_result, in_acc && pending_r == 3'd0, !out_valid)

endmodule

bind speck64_block_cipher spk_checker u_spk_checker (.*);
